[rtl/cbps_pkg.sv]
// Shared types and constants for the cubic Bezier position sampler.
// No dependencies; every other rtl file but cbps_fifo refers to this package by scoped names.
package cbps_pkg;

  localparam int TIME_W      = 32;
  localparam int POS_W       = 16;
  localparam int WEIGHT_W    = POS_W + 2;
  localparam int CFG_INDEX_W = 3;
  localparam int MID_DEPTH   = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_TIME = CFG_INDEX_W'(0),
    REG_END_TIME   = CFG_INDEX_W'(1),
    REG_START_POS  = CFG_INDEX_W'(2),
    REG_CTRL1_POS  = CFG_INDEX_W'(3),
    REG_CTRL2_POS  = CFG_INDEX_W'(4),
    REG_END_POS    = CFG_INDEX_W'(5)
  } cbps_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] diff;
    logic [TIME_W-1:0] span;
    logic              clamped;
  } cbps_job_t;

endpackage

[rtl/cbps_fifo.sv]
// Small first-in first-out queue on a register array with combinational read.
// Standalone; used between front and back and on the result side.
module cbps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

[rtl/cbps_front.sv]
// Front end: accepts sample times and classifies them into divide jobs.
// Depends on cbps_pkg for the job struct and field widths.
module cbps_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [cbps_pkg::TIME_W-1:0]   sample_time_ms,
  output logic                          full,
  input  logic [cbps_pkg::TIME_W-1:0]   start_time_ms,
  input  logic [cbps_pkg::TIME_W-1:0]   end_time_ms,
  output logic                          job_valid,
  output cbps_pkg::cbps_job_t           job,
  input  logic                          job_full
);

  logic                held;
  logic                load;
  logic                before_start;
  logic                after_end;
  logic                degenerate;
  cbps_pkg::cbps_job_t job_q;
  cbps_pkg::cbps_job_t job_next;

  assign full         = held & job_full;
  assign load         = push & ~full;
  assign before_start = sample_time_ms < start_time_ms;
  assign after_end    = sample_time_ms > end_time_ms;
  assign degenerate   = end_time_ms <= start_time_ms;

  // Saturated cases become a trivial division: 0/1 or 1/1.
  always_comb begin
    job_next.diff    = sample_time_ms - start_time_ms;
    job_next.span    = end_time_ms - start_time_ms;
    job_next.clamped = 1'b0;
    if (degenerate || before_start || after_end) begin
      job_next.clamped = 1'b1;
      job_next.span    = cbps_pkg::TIME_W'(1);
      job_next.diff    = before_start ? '0 : cbps_pkg::TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= load | (held & job_full);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_q <= job_next;
    end
  end

  assign job_valid = held;
  assign job       = job_q;

endmodule

[rtl/cbps_div.sv]
// Pipelined restoring divider: one quotient bit per stage, t = diff * 2^F / span.
// Depends on cbps_pkg for the job struct; quotient is FRACTION_BITS+1 bits wide.
module cbps_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  cbps_pkg::cbps_job_t      in_job,
  output logic                     out_valid,
  output logic [FRACTION_BITS:0]   out_t,
  output logic                     out_clamped
);

  localparam int STAGES = FRACTION_BITS + 1;
  localparam int TW     = cbps_pkg::TIME_W;

  logic                   vld     [STAGES];
  logic                   clamp_r [STAGES];
  logic [TW-1:0]          rem_r   [STAGES];
  logic [TW-1:0]          span_r  [STAGES];
  logic [FRACTION_BITS:0] quo_r   [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic [TW:0]            trial;
    logic [TW:0]            reduced;
    logic                   ge;
    logic [TW-1:0]          span_i;
    logic [FRACTION_BITS:0] quo_i;
    logic                   vld_i;
    logic                   clamp_i;

    if (k == 0) begin : g_first
      assign trial   = {1'b0, in_job.diff};
      assign span_i  = in_job.span;
      assign quo_i   = '0;
      assign vld_i   = in_valid;
      assign clamp_i = in_job.clamped;
    end else begin : g_next
      assign trial   = {rem_r[k-1], 1'b0};
      assign span_i  = span_r[k-1];
      assign quo_i   = quo_r[k-1];
      assign vld_i   = vld[k-1];
      assign clamp_i = clamp_r[k-1];
    end

    assign ge      = trial >= {1'b0, span_i};
    assign reduced = trial - {1'b0, span_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]   <= ge ? reduced[TW-1:0] : trial[TW-1:0];
      span_r[k]  <= span_i;
      quo_r[k]   <= {quo_i[FRACTION_BITS-1:0], ge};
      clamp_r[k] <= clamp_i;
    end
  end

  assign out_valid   = vld[STAGES-1];
  assign out_t       = quo_r[STAGES-1];
  assign out_clamped = clamp_r[STAGES-1];

endmodule

[rtl/cbps_blend.sv]
// Six-stage Bernstein blend: powers of t and 1-t, weighted by the four positions.
// Depends on cbps_pkg for position widths; wide products are split into partials.
module cbps_blend #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [FRACTION_BITS:0]       in_t,
  input  logic                         in_clamped,
  input  logic [cbps_pkg::POS_W-1:0]   start_position,
  input  logic [cbps_pkg::POS_W-1:0]   first_control_position,
  input  logic [cbps_pkg::POS_W-1:0]   second_control_position,
  input  logic [cbps_pkg::POS_W-1:0]   end_position,
  output logic                         out_valid,
  output logic [cbps_pkg::POS_W-1:0]   out_position,
  output logic                         out_clamped
);

  localparam int W       = FRACTION_BITS + 1;
  localparam int SQW     = 2 * W;
  localparam int CUW     = 3 * W;
  localparam int WW      = cbps_pkg::WEIGHT_W;
  localparam int PPW     = W + WW;
  localparam int TRW     = CUW + WW;
  localparam int SUMW    = TRW + 2;
  localparam int LANES   = 4;
  localparam int CHUNKS  = 3;
  localparam int NSTAGE  = 6;
  localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;

  logic            vld   [NSTAGE];
  logic            clamp [NSTAGE];

  logic [W-1:0]    u_in;
  logic [W-1:0]    t1;
  logic [W-1:0]    u1;
  logic [SQW-1:0]  uu1;
  logic [SQW-1:0]  ut1;
  logic [SQW-1:0]  tt1;
  logic [SQW-1:0]  sq_sel [LANES];
  logic [W-1:0]    x_sel  [LANES];
  logic [SQW-1:0]  plo2   [LANES];
  logic [SQW-1:0]  phi2   [LANES];
  logic [CUW-1:0]  cube3  [LANES];
  logic [WW-1:0]   wt     [LANES];
  logic [PPW-1:0]  pp4    [LANES][CHUNKS];
  logic [TRW-1:0]  term5  [LANES];
  logic [SUMW-1:0] sum_all;
  logic [cbps_pkg::POS_W-1:0] pos6;

  assign u_in = ONE - in_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGE; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    clamp[0] <= in_clamped;
    for (int i = 1; i < NSTAGE; i++) begin
      clamp[i] <= clamp[i-1];
    end
  end

  // Squares of t and 1-t, and their product.
  always_ff @(posedge clk) begin
    t1  <= in_t;
    u1  <= u_in;
    uu1 <= SQW'(u_in) * SQW'(u_in);
    ut1 <= SQW'(u_in) * SQW'(in_t);
    tt1 <= SQW'(in_t) * SQW'(in_t);
  end

  assign sq_sel[0] = uu1;
  assign x_sel[0]  = u1;
  assign sq_sel[1] = uu1;
  assign x_sel[1]  = t1;
  assign sq_sel[2] = ut1;
  assign x_sel[2]  = t1;
  assign sq_sel[3] = tt1;
  assign x_sel[3]  = t1;

  assign wt[0] = WW'(start_position);
  assign wt[1] = WW'(first_control_position) + (WW'(first_control_position) << 1);
  assign wt[2] = WW'(second_control_position) + (WW'(second_control_position) << 1);
  assign wt[3] = WW'(end_position);

  // Cubes as two half-width partial products, then recombined.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      plo2[l] <= SQW'(sq_sel[l][W-1:0]) * SQW'(x_sel[l]);
      phi2[l] <= SQW'(sq_sel[l][SQW-1:W]) * SQW'(x_sel[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      cube3[l] <= (CUW'(phi2[l]) << W) + CUW'(plo2[l]);
    end
  end

  // Weight each cube chunk by its lane weight: the position, tripled for the control points.
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      for (int c = 0; c < CHUNKS; c++) begin
        pp4[l][c] <= PPW'(cube3[l][c*W +: W]) * PPW'(wt[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      term5[l] <= TRW'(pp4[l][0]) + (TRW'(pp4[l][1]) << W) + (TRW'(pp4[l][2]) << (2 * W));
    end
  end

  assign sum_all = SUMW'(term5[0]) + SUMW'(term5[1]) + SUMW'(term5[2]) + SUMW'(term5[3]);

  always_ff @(posedge clk) begin
    pos6 <= sum_all[3*FRACTION_BITS +: cbps_pkg::POS_W];
  end

  assign out_valid    = vld[NSTAGE-1];
  assign out_clamped  = clamp[NSTAGE-1];
  assign out_position = pos6;

endmodule

[rtl/cubic_bezier_position_sampler_core.sv]
// Cubic Bezier position sampler, top level.
// Samples pass one front register, the mid queue, FRACTION_BITS+1 divider stages and
// six blend stages. Throughput: one sample per cycle while result credit remains,
// stalling when it runs out; the result queue holds FRACTION_BITS+8 entries.
// Synchronous reset empties both queues and returns the registers to their defaults.
module cubic_bezier_position_sampler_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [cbps_pkg::TIME_W-1:0]         sample_time_ms,
  output logic                                empty,
  input  logic                                pop,
  output logic [cbps_pkg::POS_W-1:0]          position_mm,
  output logic                                clamped,
  input  logic                                cfg_write,
  input  logic [cbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cbps_pkg::TIME_W-1:0]         cfg_data
);

  localparam int OUT_DEPTH = FRACTION_BITS + 8;
  localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
  localparam int JOB_W     = $bits(cbps_pkg::cbps_job_t);
  localparam int RES_W     = cbps_pkg::POS_W + 1;
  localparam logic [FRACTION_BITS:0] T_ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  logic [cbps_pkg::TIME_W-1:0] start_time;
  logic [cbps_pkg::TIME_W-1:0] end_time;
  logic [cbps_pkg::POS_W-1:0]  start_pos;
  logic [cbps_pkg::POS_W-1:0]  ctrl1_pos;
  logic [cbps_pkg::POS_W-1:0]  ctrl2_pos;
  logic [cbps_pkg::POS_W-1:0]  end_pos;

  logic                        front_valid;
  cbps_pkg::cbps_job_t         front_job;
  logic                        mid_full;
  logic                        mid_empty;
  logic [JOB_W-1:0]            mid_dout;
  cbps_pkg::cbps_job_t         issue_job;
  logic                        issue;

  logic                        div_valid;
  logic [FRACTION_BITS:0]      div_t;
  logic                        div_clamped;

  logic                        blend_valid;
  logic [cbps_pkg::POS_W-1:0]  blend_pos;
  logic                        blend_clamped;

  logic                        out_full;
  logic                        out_pop;
  logic [RES_W-1:0]            out_dout;
  logic [CREDIT_W-1:0]         credit;
  logic [CREDIT_W-1:0]         credit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= cbps_pkg::TIME_W'(1000);
      start_pos  <= '0;
      ctrl1_pos  <= '0;
      ctrl2_pos  <= '0;
      end_pos    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbps_pkg::REG_START_TIME: start_time <= cfg_data;
        cbps_pkg::REG_END_TIME:   end_time   <= cfg_data;
        cbps_pkg::REG_START_POS:  start_pos  <= cfg_data[cbps_pkg::POS_W-1:0];
        cbps_pkg::REG_CTRL1_POS:  ctrl1_pos  <= cfg_data[cbps_pkg::POS_W-1:0];
        cbps_pkg::REG_CTRL2_POS:  ctrl2_pos  <= cfg_data[cbps_pkg::POS_W-1:0];
        cbps_pkg::REG_END_POS:    end_pos    <= cfg_data[cbps_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  cbps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .sample_time_ms (sample_time_ms),
    .full           (full),
    .start_time_ms  (start_time),
    .end_time_ms    (end_time),
    .job_valid      (front_valid),
    .job            (front_job),
    .job_full       (mid_full)
  );

  cbps_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (cbps_pkg::MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_job),
    .full  (mid_full),
    .pop   (issue),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  assign issue_job = mid_dout;

  // Issue only against a reserved result slot; a slot freed this cycle counts.
  assign out_pop     = pop & ~empty;
  assign issue       = ~mid_empty & ((credit != '0) | out_pop);
  assign credit_next = credit - CREDIT_W'(issue) + CREDIT_W'(out_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= CREDIT_W'(OUT_DEPTH);
    end else begin
      credit <= credit_next;
    end
  end

  cbps_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (issue),
    .in_job      (issue_job),
    .out_valid   (div_valid),
    .out_t       (div_t),
    .out_clamped (div_clamped)
  );

  cbps_blend #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_blend (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (div_valid),
    .in_t                    (div_t),
    .in_clamped              (div_clamped),
    .start_position          (start_pos),
    .first_control_position  (ctrl1_pos),
    .second_control_position (ctrl2_pos),
    .end_position            (end_pos),
    .out_valid               (blend_valid),
    .out_position            (blend_pos),
    .out_clamped             (blend_clamped)
  );

  cbps_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (blend_valid),
    .din   ({blend_pos, blend_clamped}),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign position_mm = out_dout[RES_W-1:1];
  assign clamped     = out_dout[0];

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_W'(OUT_DEPTH))
    else $error("result credit above queue depth");

  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    blend_valid |-> !out_full)
    else $error("result arrived at a full queue");

  a_t_in_range: assert property (@(posedge clk) disable iff (rst)
    div_valid |-> (div_t <= T_ONE))
    else $error("curve parameter above one");

endmodule

[bench/cbps_position_checker.sv]
`timescale 1ns / 100ps
// Checker for the cubic Bezier position sampler: tracks register writes, predicts one
// position and clamp flag per accepted sample and compares them with popped results.
// Depends on cbps_pkg for widths and register indexes.
module cbps_position_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  logic [cbps_pkg::TIME_W-1:0]      sample_time_ms,
  input  logic                             empty,
  input  logic                             pop,
  input  logic [cbps_pkg::POS_W-1:0]       position_mm,
  input  logic                             clamped,
  input  logic                             cfg_write,
  input  logic [cbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cbps_pkg::TIME_W-1:0]      cfg_data,
  output int                               mismatch_count,
  output int                               in_flight
);

  typedef struct packed {
    logic [cbps_pkg::POS_W-1:0] position_mm;
    logic                       clamped;
  } sample_result_t;

  sample_result_t              predicted_results[$];
  logic [cbps_pkg::TIME_W-1:0] start_time;
  logic [cbps_pkg::TIME_W-1:0] end_time;
  logic [cbps_pkg::POS_W-1:0]  curve_pos[4];

  function automatic sample_result_t evaluate_curve(input logic [cbps_pkg::TIME_W-1:0] now);
    logic [63:0]    unit_t;
    logic [63:0]    t;
    logic [127:0]   tw;
    logic [127:0]   uw;
    logic [127:0]   sum;
    sample_result_t r;
    unit_t = 64'd1 << FRACTION_BITS;
    r.clamped = 1'b1;
    if (end_time <= start_time) begin
      t = (now < start_time) ? 64'd0 : unit_t;
    end else if (now < start_time) begin
      t = 64'd0;
    end else if (now > end_time) begin
      t = unit_t;
    end else begin
      r.clamped = 1'b0;
      t = ({32'd0, now - start_time} << FRACTION_BITS) / {32'd0, end_time - start_time};
    end
    tw = 128'(t);
    uw = 128'(unit_t - t);
    sum = 128'(curve_pos[0]) * uw * uw * uw
        + 128'(3) * 128'(curve_pos[1]) * uw * uw * tw
        + 128'(3) * 128'(curve_pos[2]) * uw * tw * tw
        + 128'(curve_pos[3]) * tw * tw * tw;
    r.position_mm = sum[3*FRACTION_BITS +: cbps_pkg::POS_W];
    return r;
  endfunction

  always @(posedge clk) begin
    sample_result_t want;
    if (rst) begin
      start_time = '0;
      end_time   = cbps_pkg::TIME_W'(1000);
      curve_pos  = '{default: '0};
      predicted_results.delete();
    end else begin
      if (cfg_write) begin
        case (cbps_pkg::cbps_reg_t'(cfg_index))
          cbps_pkg::REG_START_TIME: start_time = cfg_data;
          cbps_pkg::REG_END_TIME:   end_time = cfg_data;
          cbps_pkg::REG_START_POS:  curve_pos[0] = cfg_data[cbps_pkg::POS_W-1:0];
          cbps_pkg::REG_CTRL1_POS:  curve_pos[1] = cfg_data[cbps_pkg::POS_W-1:0];
          cbps_pkg::REG_CTRL2_POS:  curve_pos[2] = cfg_data[cbps_pkg::POS_W-1:0];
          cbps_pkg::REG_END_POS:    curve_pos[3] = cfg_data[cbps_pkg::POS_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        predicted_results.push_back(evaluate_curve(sample_time_ms));
      end
      if (pop && !empty) begin
        if (predicted_results.size() == 0) begin
          $error("unpredicted transaction: position_mm %0d clamped %0b", position_mm, clamped);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (position_mm !== want.position_mm) begin
            $error("position_mm: expected %0d, got %0d", want.position_mm, position_mm);
            mismatch_count++;
          end
          if (clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, clamped);
            mismatch_count++;
          end
        end
      end
    end
    in_flight <= predicted_results.size();
  end

endmodule

[bench/cubic_bezier_position_sampler_core_tb.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the cubic Bezier position sampler: directed profiles, then random
// profiles and samples with random idling on both queues; checking is in cbps_position_checker.
// Depends on cbps_pkg, cubic_bezier_position_sampler_core and cbps_position_checker.
module cubic_bezier_position_sampler_core_tb;

  localparam int FRACTION_BITS  = 16;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 3000;
  localparam int PHASE_ITEMS    = 50;
  localparam int BURST_ITEMS    = 80;
  localparam logic [cbps_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_A = cbps_pkg::CFG_INDEX_W'(6);
  localparam logic [cbps_pkg::CFG_INDEX_W-1:0] SPARE_INDEX_B = cbps_pkg::CFG_INDEX_W'(7);

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             full;
  logic [cbps_pkg::TIME_W-1:0]      sample_time_ms = '0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic [cbps_pkg::POS_W-1:0]       position_mm;
  logic                             clamped;
  logic                             cfg_write = 1'b0;
  logic [cbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cbps_pkg::TIME_W-1:0]      cfg_data = '0;
  int                               mismatch_count;
  int                               in_flight;
  int                               quiet_cycles = 0;

  logic [cbps_pkg::TIME_W-1:0] cur_start = '0;
  logic [cbps_pkg::TIME_W-1:0] cur_end = cbps_pkg::TIME_W'(1000);
  int                          tx_run = 0;
  logic                        tx_quiet = 1'b0;
  logic                        burst = 1'b0;
  int                          rx_run = 0;
  logic                        rx_quiet = 1'b0;
  logic                        rx_hold_req = 1'b0;

  cubic_bezier_position_sampler_core #(.FRACTION_BITS(FRACTION_BITS)) u_top (.*);

  cbps_position_checker #(.FRACTION_BITS(FRACTION_BITS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (rx_run == 0) begin
        rx_run = $urandom_range(8, 40);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      rx_run--;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = RX_HOLD_CYCLES;
      end else begin
        gap = rx_quiet ? 0 : $urandom_range(0, 18);
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic [cbps_pkg::TIME_W-1:0] stamp);
    int gap;
    if (tx_run == 0) begin
      tx_run = $urandom_range(8, 40);
      tx_quiet = ($urandom_range(0, 3) == 0);
    end
    tx_run--;
    gap = (burst || tx_quiet) ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    sample_time_ms <= stamp;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    push <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [cbps_pkg::CFG_INDEX_W-1:0] index,
                           input logic [cbps_pkg::TIME_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_profile(input logic [cbps_pkg::TIME_W-1:0] t0,
                                 input logic [cbps_pkg::TIME_W-1:0] t1,
                                 input logic [cbps_pkg::TIME_W-1:0] p0,
                                 input logic [cbps_pkg::TIME_W-1:0] p1,
                                 input logic [cbps_pkg::TIME_W-1:0] p2,
                                 input logic [cbps_pkg::TIME_W-1:0] p3);
    write_reg(cbps_pkg::REG_START_TIME, t0);
    write_reg(cbps_pkg::REG_END_TIME, t1);
    write_reg(cbps_pkg::REG_START_POS, p0);
    write_reg(cbps_pkg::REG_CTRL1_POS, p1);
    write_reg(cbps_pkg::REG_CTRL2_POS, p2);
    write_reg(cbps_pkg::REG_END_POS, p3);
    cur_start = t0;
    cur_end = t1;
  endtask

  function automatic logic [cbps_pkg::TIME_W-1:0] pick_position();
    logic [cbps_pkg::TIME_W-1:0] junk;
    junk = $urandom;
    case ($urandom_range(0, 5))
      0: return {junk[31:16], 16'h0000};
      1: return {junk[31:16], 16'hFFFF};
      default: return junk;
    endcase
  endfunction

  task automatic pick_profile();
    logic [cbps_pkg::TIME_W-1:0] t0;
    logic [cbps_pkg::TIME_W-1:0] t1;
    case ($urandom_range(0, 5))
      0: begin
        t0 = $urandom_range(32'hFFFFFF00, 0);
        t1 = t0 + $urandom_range(16, 1);
      end
      1: begin
        t0 = $urandom_range(32'h7FFFFFFF, 0);
        t1 = t0 + $urandom_range(32'h000FFFFF, 1);
      end
      2: begin
        t0 = $urandom_range(255, 0);
        t1 = $urandom_range(32'hFFFFFFFF, 32'hFFFFFF00);
      end
      3: begin
        t0 = $urandom;
        t1 = t0;
      end
      4: begin
        t1 = $urandom_range(32'hFFFFFFFE, 0);
        t0 = $urandom_range(32'hFFFFFFFF, t1 + 1);
      end
      default: begin
        t0 = $urandom;
        t1 = $urandom;
      end
    endcase
    program_profile(t0, t1, pick_position(), pick_position(), pick_position(), pick_position());
    if ($urandom_range(0, 3) == 0) write_reg(SPARE_INDEX_A, $urandom);
  endtask

  task automatic run_phase(input int count);
    logic [cbps_pkg::TIME_W-1:0] stamp;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: stamp = (cur_end > cur_start) ?
                                  cur_start + $urandom_range(cur_end - cur_start, 0) : $urandom;
        6: stamp = (cur_start != 0) ? $urandom_range(cur_start - 1, 0) : $urandom;
        7: stamp = (cur_end != '1) ? $urandom_range(32'hFFFFFFFF, cur_end + 1) : $urandom;
        8: begin
          case ($urandom_range(0, 3))
            0: stamp = cur_start;
            1: stamp = cur_end;
            2: stamp = cur_start - 1;
            default: stamp = cur_end + 1;
          endcase
        end
        default: stamp = $urandom;
      endcase
      send_sample(stamp);
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_sample(32'd0);
    send_sample(32'd500);
    send_sample(32'd1000);
    send_sample(32'd1001);
    drain_pipeline();

    program_profile(32'd1000, 32'd5000, 32'hABCD1234, 32'h0000FFFF, 32'hFFFF0000, 32'h5A5AFFFF);
    write_reg(SPARE_INDEX_A, 32'hFFFFFFFF);
    write_reg(SPARE_INDEX_B, 32'h00000000);
    send_sample(32'd0);
    send_sample(32'd999);
    send_sample(32'd1000);
    send_sample(32'd1001);
    send_sample(32'd3000);
    send_sample(32'd4999);
    send_sample(32'd5000);
    send_sample(32'd5001);
    send_sample(32'hFFFFFFFF);
    drain_pipeline();

    program_profile(32'h80000000, 32'h80000000, 32'hFFFF0000, 32'h0000FFFF,
                    32'h00001234, 32'hFFFFFFFF);
    send_sample(32'h7FFFFFFF);
    send_sample(32'h80000000);
    send_sample(32'hFFFFFFFF);
    drain_pipeline();

    program_profile(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF);
    send_sample(32'h00000000);
    send_sample(32'hFFFFFFFF);
    drain_pipeline();

    program_profile(32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'h0000FFFF,
                    32'h0000FFFF, 32'h00000000);
    send_sample(32'h00000000);
    send_sample(32'h80000000);
    send_sample(32'hFFFFFFFE);
    send_sample(32'hFFFFFFFF);
    drain_pipeline();

    for (int phase = 0; phase < 10; phase++) begin
      pick_profile();
      if (phase == 4) begin
        // stall the result side while samples arrive back to back
        rx_hold_req = 1'b1;
        burst = 1'b1;
        run_phase(BURST_ITEMS);
        burst = 1'b0;
      end else begin
        run_phase(PHASE_ITEMS);
      end
    end

    if (mismatch_count == 0 && in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
